// ===== hdl/cau_pkg.sv =====
// cau_pkg: widths, payload structs and the saturation helper for the
// complex arithmetic unit pipeline. No dependencies.
package cau_pkg;

  localparam int DW     = 16;          // width of one part
  localparam int FB     = 8;           // fraction bits
  localparam int PW     = 2 * DW;      // product width
  localparam int SW     = PW + 1;      // sum of two products
  localparam int MW     = PW;          // magnitude of a sum of two products
  localparam int NW     = MW + FB;     // scaled dividend
  localparam int QW     = DW + 1;      // quotient bits kept before clipping
  localparam int DSTEPS = QW;          // one pipeline stage per quotient bit

  localparam logic [NW-1:0] HALF = NW'(1) << (DW - 1);

  typedef struct packed {
    logic                 flag;
    logic signed [DW-1:0] val;
  } sat_t;

  // results already settled before the divider
  typedef struct packed {
    logic signed [DW-1:0] sum_real;
    logic signed [DW-1:0] sum_imag;
    logic signed [DW-1:0] diff_real;
    logic signed [DW-1:0] diff_imag;
    logic signed [DW-1:0] prod_real;
    logic signed [DW-1:0] prod_imag;
    logic                 sat;
    logic                 dz;
    logic                 re_neg;
    logic                 re_ovf;
    logic                 im_neg;
    logic                 im_ovf;
  } carry_t;

  // clip a sign and magnitude to the part range
  function automatic sat_t sat_part(input logic neg, input logic ovf,
                                    input logic [NW-1:0] mag);
    sat_t r;
    logic [NW-1:0] neg_mag;
    neg_mag = -mag;
    if (neg) begin
      if (ovf || mag > HALF) begin
        r.flag = 1'b1;
        r.val  = DW'(-HALF);
      end else begin
        r.flag = 1'b0;
        r.val  = neg_mag[DW-1:0];
      end
    end else begin
      if (ovf || mag > HALF - NW'(1)) begin
        r.flag = 1'b1;
        r.val  = DW'(HALF - NW'(1));
      end else begin
        r.flag = 1'b0;
        r.val  = mag[DW-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/complex_arith_unit.sv =====
// complex_arith_unit: pipelined complex add, subtract, multiply and divide
// on signed fixed point parts. Depends on cau_pkg.

// One transfer in, one transfer out per item. The unit takes a new pair of
// operands every cycle; its stages are multiply, combine, scale and
// compare, one stage per quotient bit of the restoring divider, and clip,
// and the whole pipeline holds while a finished result is not taken. Products
// and quotients are truncated toward zero, every part clips to range and
// raises saturated, and a zero divisor gives a zero quotient with
// divide_by_zero set.
module complex_arith_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [cau_pkg::DW-1:0] a_real,
  input  logic signed [cau_pkg::DW-1:0] a_imag,
  input  logic signed [cau_pkg::DW-1:0] b_real,
  input  logic signed [cau_pkg::DW-1:0] b_imag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [cau_pkg::DW-1:0] sum_real,
  output logic signed [cau_pkg::DW-1:0] sum_imag,
  output logic signed [cau_pkg::DW-1:0] diff_real,
  output logic signed [cau_pkg::DW-1:0] diff_imag,
  output logic signed [cau_pkg::DW-1:0] prod_real,
  output logic signed [cau_pkg::DW-1:0] prod_imag,
  output logic signed [cau_pkg::DW-1:0] quot_real,
  output logic signed [cau_pkg::DW-1:0] quot_imag,
  output logic                          saturated,
  output logic                          divide_by_zero
);
  import cau_pkg::*;

  logic en;

  // whole pipeline advances when the output slot is free or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- stage 1: multiplies, sums and differences
  logic                 v1;
  logic signed [PW-1:0] rr, ii, ir, ri, sqr, sqi;
  sat_t                 s_sr, s_si, s_dr, s_di;
  logic signed [DW:0]   add_r, add_i, sub_r, sub_i;

  function automatic sat_t clip_short(input logic signed [DW:0] x);
    logic [DW:0] m;
    m = x[DW] ? -x : x;
    return sat_part(x[DW], 1'b0, NW'(m));
  endfunction

  assign add_r = {a_real[DW-1], a_real} + {b_real[DW-1], b_real};
  assign add_i = {a_imag[DW-1], a_imag} + {b_imag[DW-1], b_imag};
  assign sub_r = {a_real[DW-1], a_real} - {b_real[DW-1], b_real};
  assign sub_i = {a_imag[DW-1], a_imag} - {b_imag[DW-1], b_imag};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr   <= a_real * b_real;
      ii   <= a_imag * b_imag;
      ir   <= a_imag * b_real;
      ri   <= a_real * b_imag;
      sqr  <= b_real * b_real;
      sqi  <= b_imag * b_imag;
      s_sr <= clip_short(add_r);
      s_si <= clip_short(add_i);
      s_dr <= clip_short(sub_r);
      s_di <= clip_short(sub_i);
    end
  end

  // ---------------- stage 2: combine products, divisor
  logic                 v2;
  logic signed [SW-1:0] p_re, p_im, n_re, n_im;
  logic [PW-1:0]        den2;
  sat_t                 s2_sr, s2_si, s2_dr, s2_di;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_re  <= {rr[PW-1], rr} - {ii[PW-1], ii};
      p_im  <= {ir[PW-1], ir} + {ri[PW-1], ri};
      n_re  <= {rr[PW-1], rr} + {ii[PW-1], ii};
      n_im  <= {ir[PW-1], ir} - {ri[PW-1], ri};
      den2  <= PW'(sqr) + PW'(sqi);
      s2_sr <= s_sr;
      s2_si <= s_si;
      s2_dr <= s_dr;
      s2_di <= s_di;
    end
  end

  // ---------------- stage 3: product clipping, dividend setup
  logic [SW-1:0] pm_re, pm_im, nm_re, nm_im;
  logic          zero_den, ovf_re, ovf_im;
  sat_t          c_pr, c_pi;
  carry_t        c3;

  assign pm_re    = p_re[SW-1] ? -p_re : p_re;
  assign pm_im    = p_im[SW-1] ? -p_im : p_im;
  assign nm_re    = n_re[SW-1] ? -n_re : n_re;
  assign nm_im    = n_im[SW-1] ? -n_im : n_im;
  assign zero_den = (den2 == '0);
  assign c_pr     = sat_part(p_re[SW-1], 1'b0, NW'(pm_re >> FB));
  assign c_pi     = sat_part(p_im[SW-1], 1'b0, NW'(pm_im >> FB));
  // quotient would need more than QW bits
  assign ovf_re   = NW'(nm_re[MW-1:0] >> (QW - FB)) >= NW'(den2);
  assign ovf_im   = NW'(nm_im[MW-1:0] >> (QW - FB)) >= NW'(den2);

  always_comb begin
    c3.sum_real  = s2_sr.val;
    c3.sum_imag  = s2_si.val;
    c3.diff_real = s2_dr.val;
    c3.diff_imag = s2_di.val;
    c3.prod_real = c_pr.val;
    c3.prod_imag = c_pi.val;
    c3.sat       = s2_sr.flag | s2_si.flag | s2_dr.flag | s2_di.flag
                 | c_pr.flag | c_pi.flag;
    c3.dz        = zero_den;
    c3.re_neg    = n_re[SW-1];
    c3.re_ovf    = ovf_re;
    c3.im_neg    = n_im[SW-1];
    c3.im_ovf    = ovf_im;
  end

  // ---------------- divider stages, one quotient bit each
  logic                 dv   [0:DSTEPS];
  carry_t               dc   [0:DSTEPS];
  logic [NW-1:0]        rem_re [0:DSTEPS];
  logic [NW-1:0]        rem_im [0:DSTEPS];
  logic [QW-1:0]        q_re [0:DSTEPS];
  logic [QW-1:0]        q_im [0:DSTEPS];
  logic [PW-1:0]        dden [0:DSTEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc[0]     <= c3;
      rem_re[0] <= {nm_re[MW-1:0], FB'(0)};
      rem_im[0] <= {nm_im[MW-1:0], FB'(0)};
      q_re[0]   <= '0;
      q_im[0]   <= '0;
      dden[0]   <= den2;
    end
  end

  for (genvar j = 0; j < DSTEPS; j++) begin : g_div
    localparam int K = DSTEPS - 1 - j;
    logic [NW+QW-1:0] dsh;
    logic             ge_re, ge_im;

    assign dsh   = (NW+QW)'(dden[j]) << K;
    assign ge_re = (NW+QW)'(rem_re[j]) >= dsh;
    assign ge_im = (NW+QW)'(rem_im[j]) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dc[j+1]     <= dc[j];
        dden[j+1]   <= dden[j];
        rem_re[j+1] <= ge_re ? rem_re[j] - dsh[NW-1:0] : rem_re[j];
        rem_im[j+1] <= ge_im ? rem_im[j] - dsh[NW-1:0] : rem_im[j];
        q_re[j+1]   <= q_re[j] | (QW'(ge_re) << K);
        q_im[j+1]   <= q_im[j] | (QW'(ge_im) << K);
      end
    end
  end

  // ---------------- final stage: quotient clipping, output register
  carry_t cf;
  sat_t   c_qr, c_qi;

  assign cf   = dc[DSTEPS];
  assign c_qr = sat_part(cf.re_neg, cf.re_ovf, NW'(q_re[DSTEPS]));
  assign c_qi = sat_part(cf.im_neg, cf.im_ovf, NW'(q_im[DSTEPS]));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[DSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_real       <= cf.sum_real;
      sum_imag       <= cf.sum_imag;
      diff_real      <= cf.diff_real;
      diff_imag      <= cf.diff_imag;
      prod_real      <= cf.prod_real;
      prod_imag      <= cf.prod_imag;
      quot_real      <= cf.dz ? '0 : c_qr.val;
      quot_imag      <= cf.dz ? '0 : c_qi.val;
      saturated      <= cf.sat | (!cf.dz & (c_qr.flag | c_qi.flag));
      divide_by_zero <= cf.dz;
    end
  end

endmodule
